>>> hdl/cst_pkg.sv
// cst_pkg: shared types, result codes and the standard genetic code table
// for the codon stream translator. no dependencies.
`timescale 1ns / 1ps

package cst_pkg;

  typedef enum logic [1:0] {
    KIND_AMINO = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_G = 2'd1;
  localparam logic [1:0] BASE_C = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_STOP    = 8'h2A;

  // first character is codon 0 (AAA), held in the top byte
  localparam logic [8*64-1:0] CODE_TABLE =
    {"KKNNRRSSTTTTIMII", "EEDDGGGGAAAAVVVV",
     "QQHHRRRRPPPPLLLL", "**YY*WCCSSSSLLFF"};

  typedef struct packed {
    logic       is_newline;
    logic       is_base;
    logic [1:0] base;
  } char_class_t;

  typedef struct packed {
    logic       has_result;
    kind_t      kind;
    logic [7:0] amino;
  } result_t;

  function automatic logic [7:0] codon_letter(input logic [5:0] codon);
    logic [5:0] slot;
    slot = 6'd63 - codon;
    return CODE_TABLE[{slot, 3'b000} +: 8];
  endfunction

endpackage

>>> hdl/cst_base_decode.sv
// cst_base_decode: classifies one ascii character as newline, base or other
// and gives the two-bit base code. depends on cst_pkg.
`timescale 1ns / 1ps

module cst_base_decode
  import cst_pkg::*;
(
  input  logic [7:0]  char_in,
  output char_class_t char_class
);

  always_comb begin
    char_class.is_newline = (char_in == CHAR_NEWLINE);
    char_class.is_base    = 1'b1;
    char_class.base       = BASE_A;
    unique case (char_in)
      "A", "a": char_class.base = BASE_A;
      "G", "g": char_class.base = BASE_G;
      "C", "c": char_class.base = BASE_C;
      "T", "t": char_class.base = BASE_T;
      default: char_class.is_base = 1'b0;
    endcase
  end

endmodule

>>> hdl/cst_codon_engine.sv
// cst_codon_engine: scan/translate mode, three-base window and codon lookup.
// depends on cst_pkg.
`timescale 1ns / 1ps

module cst_codon_engine
  import cst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  char_class_t char_class,
  output result_t     result
);

  logic       translating_r, translating_nxt;
  logic [5:0] window_r, window_nxt;
  logic [1:0] fill_r, fill_nxt;

  logic [5:0] win_shift;
  logic [1:0] fill_inc;
  logic       start_hit;
  logic [7:0] letter;

  always_comb begin
    win_shift = {window_r[3:0], char_class.base};
    fill_inc  = (fill_r == 2'd3) ? 2'd3 : fill_r + 2'd1;
    start_hit = (win_shift[5:4] != BASE_G) && (win_shift[3:2] == BASE_T) &&
                (win_shift[1:0] == BASE_G);
    letter    = codon_letter(win_shift);

    translating_nxt   = translating_r;
    window_nxt        = window_r;
    fill_nxt          = fill_r;
    result.has_result = 1'b0;
    result.kind       = KIND_AMINO;
    result.amino      = 8'd0;

    priority if (char_class.is_newline) begin
      translating_nxt   = 1'b0;
      window_nxt        = 6'd0;
      fill_nxt          = 2'd0;
      result.has_result = 1'b1;
      result.kind       = KIND_END;
    end else if (!char_class.is_base) begin
      translating_nxt   = 1'b0;
      window_nxt        = 6'd0;
      fill_nxt          = 2'd0;
      result.has_result = 1'b1;
      result.kind       = KIND_ERROR;
    end else begin
      window_nxt = win_shift;
      fill_nxt   = fill_inc;
      if (fill_inc == 2'd3 && (translating_r || start_hit)) begin
        window_nxt        = 6'd0;
        fill_nxt          = 2'd0;
        translating_nxt   = (letter != CHAR_STOP);
        result.has_result = 1'b1;
        result.kind       = KIND_AMINO;
        result.amino      = letter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      translating_r <= 1'b0;
      window_r      <= 6'd0;
      fill_r        <= 2'd0;
    end else if (advance) begin
      translating_r <= translating_nxt;
      window_r      <= window_nxt;
      fill_r        <= fill_nxt;
    end
  end

endmodule

>>> hdl/codon_stream_translator.sv
// codon_stream_translator: top level with input register and result register.
// depends on cst_pkg, cst_base_decode and cst_codon_engine.
`timescale 1ns / 1ps

// Takes one ASCII character per cycle and emits amino letters from the
// standard genetic code, a kind of 1 for an invalid character and a kind of 2
// for newline. Sustained rate is one character per cycle with no stall from
// the block itself; it stalls only while out_stall holds a pending result.
// Each character passes the input register and then the result register, with
// base decode, window update and codon table lookup done in the single logic
// stage between them. Bases that yield no amino letter produce no output transaction.

module codon_stream_translator
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_amino
);

  logic        char_valid_r;
  logic [7:0]  char_r;
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_amino_r;

  logic        advance;
  char_class_t char_class;
  result_t     result;

  assign advance  = char_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = char_valid_r && !advance;

  cst_base_decode u_decode (
    .char_in    (char_r),
    .char_class (char_class)
  );

  cst_codon_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .char_class (char_class),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_valid_r <= 1'b0;
    end else if (!in_stall) begin
      char_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      char_r <= in_char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= result.has_result;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.has_result) begin
      out_kind_r  <= result.kind;
      out_amino_r <= result.amino;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_amino = out_amino_r;

endmodule

>>> tb/sv/tb_codon_stream_translator.sv
// tb_codon_stream_translator: self-checking testbench for the codon stream translator,
// a directed table then random gene-like sequences, checked against a local predictor.
// depends on cst_pkg and codon_stream_translator.
`timescale 1ns / 1ps

module tb_codon_stream_translator;
  import cst_pkg::*;

  localparam int RANDOM_CHARS = 1400;
  localparam int DIRECTED_ROWS = 26;

  // codon index is {first, middle, last} base code, AAA first
  localparam bit [8*64-1:0] AMINO_LETTERS =
    {"KKNNRRSSTTTTIMII", "EEDDGGGGAAAAVVVV",
     "QQHHRRRRPPPPLLLL", "**YY*WCCSSSSLLFF"};

  typedef struct packed {
    kind_t      kind;
    logic [7:0] amino;
  } emitted_t;

  typedef struct packed {
    logic [7:0] ch;
    bit         typed;
    bit         has;
    kind_t      kind;
    logic [7:0] amino;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_amino;

  // predictor state
  bit         in_frame;
  logic [5:0] codon_window;
  logic [1:0] window_count;

  emitted_t pending_letters[$];
  bit       no_idle;
  bit       use_typed;
  dir_row_t typed_row;

  int chars_sent;
  int letters_seen;
  int stops_seen;
  int errors_seen;
  int ends_seen;
  int mismatch_count;

  dir_row_t dir_rows [DIRECTED_ROWS] = '{
    '{"A",   1'b1, 1'b0, KIND_AMINO, 8'h00},
    '{"T",   1'b1, 1'b0, KIND_AMINO, 8'h00},
    '{"G",   1'b1, 1'b1, KIND_AMINO, "M"},
    '{"g",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"a",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"c",   1'b1, 1'b1, KIND_AMINO, "D"},
    '{"G",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"A",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"T",   1'b1, 1'b1, KIND_AMINO, "D"},
    '{"t",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"a",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"a",   1'b1, 1'b1, KIND_AMINO, "*"},
    '{"G",   1'b1, 1'b0, KIND_AMINO, 8'h00},
    '{"T",   1'b1, 1'b0, KIND_AMINO, 8'h00},
    '{"G",   1'b1, 1'b0, KIND_AMINO, 8'h00},
    '{"T",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"T",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"G",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{8'hFF, 1'b1, 1'b1, KIND_ERROR, 8'h00},
    '{"c",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"T",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"g",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{"a",   1'b0, 1'b0, KIND_AMINO, 8'h00},
    '{8'h0A, 1'b1, 1'b1, KIND_END,   8'h00},
    '{8'h00, 1'b1, 1'b1, KIND_ERROR, 8'h00},
    '{8'h0D, 1'b1, 1'b1, KIND_ERROR, 8'h00}
  };

  codon_stream_translator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_amino  (out_amino)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] base_letter(input logic [1:0] b, input bit lower);
    logic [7:0] up;
    case (b)
      BASE_A:  up = "A";
      BASE_G:  up = "G";
      BASE_C:  up = "C";
      default: up = "T";
    endcase
    return lower ? (up | 8'h20) : up;
  endfunction

  task automatic clear_window();
    in_frame = 1'b0;
    codon_window = 6'd0;
    window_count = 2'd0;
  endtask

  task automatic translate_char(input logic [7:0] ch, output bit emits, output emitted_t res);
    logic [1:0] b;
    bit is_base;
    int slot;
    emits = 1'b0;
    res.kind = KIND_AMINO;
    res.amino = 8'h00;
    is_base = 1'b1;
    case (ch)
      "A", "a": b = BASE_A;
      "G", "g": b = BASE_G;
      "C", "c": b = BASE_C;
      "T", "t": b = BASE_T;
      default: begin
        b = BASE_A;
        is_base = 1'b0;
      end
    endcase
    if (ch == CHAR_NEWLINE) begin
      clear_window();
      emits = 1'b1;
      res.kind = KIND_END;
    end else if (!is_base) begin
      clear_window();
      emits = 1'b1;
      res.kind = KIND_ERROR;
    end else begin
      codon_window = {codon_window[3:0], b};
      if (window_count != 2'd3) window_count = window_count + 2'd1;
      if (window_count == 2'd3 && (in_frame || (codon_window[5:4] != BASE_G &&
          codon_window[3:2] == BASE_T && codon_window[1:0] == BASE_G))) begin
        slot = 63 - int'(codon_window);
        res.amino = AMINO_LETTERS[slot*8 +: 8];
        emits = 1'b1;
        in_frame = (res.amino != CHAR_STOP);
        codon_window = 6'd0;
        window_count = 2'd0;
      end
    end
  endtask

  task automatic drive_char(input logic [7:0] ch);
    int gap;
    bit emits;
    emitted_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    translate_char(ch, emits, res);
    if (use_typed) begin
      emits = typed_row.has;
      res.kind = typed_row.kind;
      res.amino = typed_row.amino;
    end
    if (emits) pending_letters.push_back(res);
  endtask

  task automatic send_codon(input logic [5:0] codon);
    drive_char(base_letter(codon[5:4], 1'($urandom_range(0, 1))));
    drive_char(base_letter(codon[3:2], 1'($urandom_range(0, 1))));
    drive_char(base_letter(codon[1:0], 1'($urandom_range(0, 1))));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // result side stalls
  initial begin
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    emitted_t want;
    if (rst_n && out_valid && !out_stall) begin
      case (out_kind)
        KIND_AMINO: if (out_amino == CHAR_STOP) stops_seen++; else letters_seen++;
        KIND_ERROR: errors_seen++;
        default:    ends_seen++;
      endcase
      if (pending_letters.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction kind %0d amino 0x%02h",
                                out_kind, out_amino));
      end else begin
        want = pending_letters.pop_front();
        if (out_kind !== want.kind || out_amino !== want.amino)
          flag_mismatch($sformatf("expected kind %0d amino 0x%02h, got kind %0d amino 0x%02h",
                                  want.kind, want.amino, out_kind, out_amino));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_letters.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int seq_kind;
    int body_len;
    int target;
    bit drained_mid;
    logic [5:0] starts [3];
    logic [5:0] stops [3];
    starts = '{{BASE_A, BASE_T, BASE_G}, {BASE_C, BASE_T, BASE_G}, {BASE_T, BASE_T, BASE_G}};
    stops = '{{BASE_T, BASE_A, BASE_A}, {BASE_T, BASE_A, BASE_G}, {BASE_T, BASE_G, BASE_A}};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_in <= 8'h00;
    no_idle = 1'b0;
    use_typed = 1'b0;
    drained_mid = 1'b0;
    clear_window();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed_row = dir_rows[i];
      use_typed = dir_rows[i].typed;
      drive_char(dir_rows[i].ch);
    end
    use_typed = 1'b0;
    drain_results();

    target = chars_sent + RANDOM_CHARS;
    while (chars_sent < target) begin
      seq_kind = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 5) == 0);
      if (seq_kind < 7) begin
        // scan junk, start codon, body, then a stop, a newline or nothing
        repeat ($urandom_range(0, 4))
          drive_char(base_letter(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
        send_codon(starts[2'($urandom_range(0, 2))]);
        body_len = $urandom_range(1, 24);
        for (int k = 0; k < body_len; k++) begin
          if ($urandom_range(0, 39) == 0) begin
            drive_char($urandom_range(0, 1) ? CHAR_NEWLINE : 8'($urandom_range(0, 255)));
            break;
          end
          send_codon(6'($urandom_range(0, 63)));
        end
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: send_codon(stops[2'($urandom_range(0, 2))]);
          12, 13, 14, 15, 16: drive_char(CHAR_NEWLINE);
          default: ;
        endcase
      end else if (seq_kind < 9) begin
        repeat ($urandom_range(1, 8)) drive_char(8'($urandom_range(0, 255)));
      end else begin
        // near misses around the start pattern
        repeat ($urandom_range(3, 12))
          drive_char(base_letter($urandom_range(0, 1) ? BASE_G : BASE_T,
                                 1'($urandom_range(0, 1))));
      end
      if (!drained_mid && chars_sent > target - RANDOM_CHARS / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d characters sent; results: %0d amino letters, %0d stops, %0d errors, %0d ends",
             chars_sent, letters_seen, stops_seen, errors_seen, ends_seen);
    $display("start codons ATG/CTG/TTG, sliding scan window, upper and lower case, noise bytes");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> codon_stream_translator.f
hdl/cst_pkg.sv
hdl/cst_base_decode.sv
hdl/cst_codon_engine.sv
hdl/codon_stream_translator.sv
tb/sv/tb_codon_stream_translator.sv
